>>> rtl/xsbs_pkg.sv
// Shared types and constants for the selected-block XOR scan.
// Used by the front, queue, back and top-level modules; no dependencies.
`timescale 1ns / 1ps

package xsbs_pkg;

    localparam int WORD_W      = 64;
    localparam int VBYTE_W     = 8;
    localparam int POS_W       = 6;   // holds a word index from 0 to 63
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_VECTOR_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Z_LOW       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Z_HIGH      = 2'd2;

    typedef struct packed {
        logic              vector_mode;
        logic [WORD_W-1:0] z_low;
        logic [WORD_W-1:0] z_high;
    } xsbs_cfg_t;

    // One classified word on its way to the accumulator
    typedef struct packed {
        logic [WORD_W-1:0] word;    // already zeroed when the block is not selected
        logic [POS_W-1:0]  pos;     // word index within the block
        logic              last;    // final word of the scan
    } xsbs_item_t;

endpackage

>>> rtl/xsbs_front.sv
// Front end: accepts scan words, tracks word/block position, decides block selection.
// Depends on xsbs_pkg.
`timescale 1ns / 1ps

module xsbs_front import xsbs_pkg::*; #(
    parameter int WORDS_PER_BLOCK = 4,
    parameter int BLOCK_BYTES     = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  xsbs_cfg_t          cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [WORD_W-1:0]  in_word,
    input  logic               in_select,
    input  logic [VBYTE_W-1:0] in_vbyte,
    input  logic               in_last,
    output logic               push,
    output xsbs_item_t         push_item,
    input  logic               queue_full
);

    localparam int WP_W = (WORDS_PER_BLOCK > 1) ? $clog2(WORDS_PER_BLOCK) : 1;
    localparam int BP_W = $clog2(BLOCK_BYTES * 8);

    logic [WP_W-1:0] wp_reg, wp_next;
    logic [BP_W-1:0] bp_reg, bp_next;
    logic            sel_reg, sel_next;

    logic [6:0]         bp_ext;
    logic [127:0]       z_all;
    logic [VBYTE_W-1:0] z_byte;
    logic [VBYTE_W-1:0] vec_bits;
    logic               sel_now;

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;

    assign bp_ext   = 7'(bp_reg);
    assign z_all    = {cfg.z_high, cfg.z_low};
    assign z_byte   = z_all[{bp_ext[6:3], 3'b000} +: 8];
    assign vec_bits = (in_select ? z_byte : '0) ^ in_vbyte;

    always_comb begin
        // Sample selection on the first word of a block, hold it for the rest
        if (wp_reg == '0) begin
            sel_now = cfg.vector_mode ? vec_bits[bp_ext[2:0]] : in_select;
        end else begin
            sel_now = sel_reg;
        end

        wp_next  = wp_reg;
        bp_next  = bp_reg;
        sel_next = sel_reg;
        if (push) begin
            sel_next = sel_now;
            if (in_last) begin
                wp_next  = '0;
                bp_next  = '0;
                sel_next = 1'b0;
            end else if (wp_reg == WP_W'(WORDS_PER_BLOCK - 1)) begin
                wp_next = '0;
                if (bp_reg == BP_W'(BLOCK_BYTES * 8 - 1)) begin
                    bp_next = '0;
                end else begin
                    bp_next = bp_reg + 1'b1;
                end
            end else begin
                wp_next = wp_reg + 1'b1;
            end
        end
    end

    assign push_item.word = sel_now ? in_word : '0;
    assign push_item.pos  = POS_W'(wp_reg);
    assign push_item.last = in_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            bp_reg  <= '0;
            sel_reg <= 1'b0;
        end else begin
            wp_reg  <= wp_next;
            bp_reg  <= bp_next;
            sel_reg <= sel_next;
        end
    end

endmodule

>>> rtl/xsbs_queue.sv
// Short FIFO of classified words between the front and back ends.
// Depends on xsbs_pkg.
`timescale 1ns / 1ps

module xsbs_queue import xsbs_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  xsbs_item_t push_item,
    output logic       full,
    input  logic       pop,
    output logic       pop_valid,
    output xsbs_item_t pop_item
);

    xsbs_item_t             mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] cnt_reg, cnt_next;

    assign full      = (cnt_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign pop_item  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

>>> rtl/xsbs_back.sv
// Back end: XORs classified words into the block accumulator and shifts it out at scan end.
// Depends on xsbs_pkg.
`timescale 1ns / 1ps

module xsbs_back import xsbs_pkg::*; #(
    parameter int WORDS_PER_BLOCK = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              item_valid,
    input  xsbs_item_t        item,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [WORD_W-1:0] out_word,
    output logic              out_last
);

    localparam int WP_W = (WORDS_PER_BLOCK > 1) ? $clog2(WORDS_PER_BLOCK) : 1;

    logic [WORD_W-1:0] acc_reg   [WORDS_PER_BLOCK];
    logic [WORD_W-1:0] acc_next  [WORDS_PER_BLOCK];
    logic [WORD_W-1:0] acc_shift [WORDS_PER_BLOCK];
    logic              emit_reg, emit_next;
    logic [WP_W-1:0]   cnt_reg, cnt_next;
    logic              out_fire;

    assign pop       = item_valid && !emit_reg;
    assign out_valid = emit_reg;
    assign out_word  = acc_reg[0];
    assign out_last  = (cnt_reg == WP_W'(WORDS_PER_BLOCK - 1));
    assign out_fire  = emit_reg && out_ready;

    // Shifting out leaves zeros behind, which clears the accumulator
    always_comb begin
        for (int k = 0; k < WORDS_PER_BLOCK - 1; k++) begin
            acc_shift[k] = acc_reg[k + 1];
        end
        acc_shift[WORDS_PER_BLOCK - 1] = '0;
    end

    always_comb begin
        emit_next = emit_reg;
        cnt_next  = cnt_reg;
        for (int k = 0; k < WORDS_PER_BLOCK; k++) begin
            acc_next[k] = acc_reg[k];
            if (pop && item.pos == POS_W'(k)) begin
                acc_next[k] = acc_reg[k] ^ item.word;
            end else if (out_fire) begin
                acc_next[k] = acc_shift[k];
            end
        end
        if (pop && item.last) begin
            emit_next = 1'b1;
            cnt_next  = '0;
        end else if (out_fire) begin
            if (out_last) begin
                emit_next = 1'b0;
                cnt_next  = '0;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emit_reg <= 1'b0;
            cnt_reg  <= '0;
            for (int k = 0; k < WORDS_PER_BLOCK; k++) begin
                acc_reg[k] <= '0;
            end
        end else begin
            emit_reg <= emit_next;
            cnt_reg  <= cnt_next;
            for (int k = 0; k < WORDS_PER_BLOCK; k++) begin
                acc_reg[k] <= acc_next[k];
            end
        end
    end

endmodule

>>> rtl/xor_selected_block_scan.sv
// Top level of the selected-block XOR scan: configuration registers and the
// front / queue / back pipeline. Depends on xsbs_pkg, xsbs_front, xsbs_queue, xsbs_back.
`timescale 1ns / 1ps

// Usage
//   s_axis carries the scan, one memory word per handshake, in block order.
//   Each group of WORDS_PER_BLOCK words forms a block; the tuser flag of a
//   block's first word (plus the blockvector byte in vector mode) decides
//   whether the block is XORed into the accumulator. tlast marks the final
//   word of the whole scan.
//   m_axis then delivers the accumulated block, WORDS_PER_BLOCK words with
//   tlast on the last one; the accumulator and position counters start over.
// Timing
//   A word enters the queue at its accepting edge and is folded into the
//   accumulator from the queue head; the end-of-scan word also sets the emit
//   register, which drives m_axis_tvalid. The block drains at one word per
//   cycle while m_axis_tready is high, and meanwhile the four-entry queue
//   takes words of the next scan until it fills, which stalls s_axis.
//   Within a scan s_axis can take a new word while older words still queue.
// Reset and stalls
//   aresetn (synchronous, active low) clears configuration, counters, queue
//   and accumulator. When m_axis_tready is low the current result word holds;
//   once the queue is full s_axis_tready drops until the back end drains.
//   Write configuration only while the block is idle.

module xor_selected_block_scan import xsbs_pkg::*; #(
    parameter int WORDS_PER_BLOCK = 4,
    parameter int BLOCK_BYTES     = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    // scan input
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [71:0]          s_axis_tdata,   // [63:0] rom_word, [71:64] vector_byte
    input  logic                 s_axis_tuser,   // [0] select_bit
    input  logic                 s_axis_tlast,   // end_of_scan
    // result output
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [63:0]          m_axis_tdata,   // [63:0] result_word
    output logic                 m_axis_tlast    // result_last
);

    xsbs_cfg_t  cfg_reg, cfg_next;
    logic       push;
    xsbs_item_t push_item;
    logic       queue_full;
    logic       pop;
    logic       pop_valid;
    xsbs_item_t pop_item;

    // Register writes; an unknown index is dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_VECTOR_MODE: cfg_next.vector_mode = cfg_data[0];
                REG_Z_LOW:       cfg_next.z_low       = cfg_data;
                REG_Z_HIGH:      cfg_next.z_high      = cfg_data;
                default:         cfg_next             = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: classify each word as it arrives
    xsbs_front #(
        .WORDS_PER_BLOCK (WORDS_PER_BLOCK),
        .BLOCK_BYTES     (BLOCK_BYTES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_word    (s_axis_tdata[63:0]),
        .in_select  (s_axis_tuser),
        .in_vbyte   (s_axis_tdata[71:64]),
        .in_last    (s_axis_tlast),
        .push       (push),
        .push_item  (push_item),
        .queue_full (queue_full)
    );

    // Queue: decouple intake from accumulation and drain
    xsbs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_item  (pop_item)
    );

    // Back: accumulate and emit the block at scan end
    xsbs_back #(
        .WORDS_PER_BLOCK (WORDS_PER_BLOCK)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (pop_valid),
        .item       (pop_item),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_word   (m_axis_tdata),
        .out_last   (m_axis_tlast)
    );

endmodule
